/* hw/rtl/utf8_to_lcd_transliterator_macros.svh */
// Assertion shorthands for the checker file.
// Each macro expects clk in the scope where it is used; the NOW and NEXT forms also expect arst_n.
`ifndef UTF8_TO_LCD_TRANSLITERATOR_MACROS_SVH
`define UTF8_TO_LCD_TRANSLITERATOR_MACROS_SVH

// Same-cycle implication, off while reset is asserted
`define U2L_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted
`define U2L_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Same-cycle implication that also holds across reset
`define U2L_ASSERT_ALWAYS(label, ante, cons, msg) \
	label: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/u2l_pkg.sv */
package u2l_pkg;

	// Lead byte of the two-byte Latin-1 supplement range handled here
	localparam logic [7:0] LEAD_LATIN    = 8'hC3;

	// Lead byte classes: mask and match for 2-, 3- and 4-byte sequences
	localparam logic [7:0] LEAD2_MASK    = 8'hE0;
	localparam logic [7:0] LEAD2_MATCH   = 8'hC0;
	localparam logic [7:0] LEAD3_MASK    = 8'hF0;
	localparam logic [7:0] LEAD3_MATCH   = 8'hE0;
	localparam logic [7:0] LEAD4_MASK    = 8'hF8;
	localparam logic [7:0] LEAD4_MATCH   = 8'hF0;

	// Bytes below this are plain ASCII
	localparam logic [7:0] ASCII_LIMIT   = 8'h80;

	// Output codes
	localparam logic [7:0] CHAR_UNKNOWN  = 8'h3F;
	localparam logic [7:0] GLYPH_O_UMLAUT = 8'h07;
	localparam logic [7:0] GLYPH_U_UMLAUT = 8'h06;
	localparam logic [7:0] CHAR_NONE     = 8'h00;

	// Continuation bytes to drop after a lead
	localparam logic [1:0] SKIP_NONE     = 2'd0;
	localparam logic [1:0] SKIP_ONE      = 2'd1;
	localparam logic [1:0] SKIP_TWO      = 2'd2;
	localparam logic [1:0] SKIP_THREE    = 2'd3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic [1:0] bytes_after;
	} in_word_t;

	typedef struct packed {
		logic       out_valid;
		logic [7:0] out_char;
		logic       text_end;
	} out_word_t;

	// Decoder state carried from one byte to the next
	typedef struct packed {
		logic [1:0] skip_left;
		logic       latin_pending;
	} dec_state_t;

	// Map the tail byte of a 0xC3 pair to its ASCII base letter or LCD glyph
	function automatic logic [7:0] latin_map(input logic [7:0] b);
		logic [7:0] ch;
		ch = CHAR_UNKNOWN;
		if (b >= 8'h80 && b <= 8'h86)      ch = "A";
		else if (b == 8'h87)               ch = "C";
		else if (b >= 8'h88 && b <= 8'h8B) ch = "E";
		else if (b >= 8'h8C && b <= 8'h8F) ch = "I";
		else if (b == 8'h90)               ch = "D";
		else if (b == 8'h91)               ch = "N";
		else if (b >= 8'h92 && b <= 8'h95) ch = "O";
		else if (b == 8'h96)               ch = GLYPH_O_UMLAUT;
		else if (b == 8'h98)               ch = "O";
		else if (b >= 8'h99 && b <= 8'h9B) ch = "U";
		else if (b == 8'h9C)               ch = GLYPH_U_UMLAUT;
		else if (b == 8'h9D)               ch = "Y";
		else if (b >= 8'hA0 && b <= 8'hA6) ch = "a";
		else if (b == 8'hA7)               ch = "c";
		else if (b >= 8'hA8 && b <= 8'hAB) ch = "e";
		else if (b >= 8'hAC && b <= 8'hAF) ch = "i";
		else if (b == 8'hB0)               ch = "d";
		else if (b == 8'hB1)               ch = "n";
		else if (b >= 8'hB2 && b <= 8'hB5) ch = "o";
		else if (b == 8'hB6)               ch = GLYPH_O_UMLAUT;
		else if (b == 8'hB8)               ch = "o";
		else if (b >= 8'hB9 && b <= 8'hBB) ch = "u";
		else if (b == 8'hBC)               ch = GLYPH_U_UMLAUT;
		else if (b == 8'hBD || b == 8'hBF) ch = "y";
		return ch;
	endfunction

endpackage

/* hw/rtl/u2l_if.sv */
// Byte channel into the transliterator
interface u2l_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic [1:0] bytes_after;

	modport source (output valid, output in_byte, output bytes_after, input ready);
	modport sink   (input valid, input in_byte, input bytes_after, output ready);
endinterface

// Character channel out of the transliterator
interface u2l_out_if;
	logic       valid;
	logic       ready;
	logic       out_valid;
	logic [7:0] out_char;
	logic       text_end;

	modport source (output valid, output out_valid, output out_char, output text_end,
		input ready);
	modport sink   (input valid, input out_valid, input out_char, input text_end,
		output ready);
endinterface

/* hw/rtl/u2l_decode.sv */
module u2l_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  u2l_pkg::in_word_t word,
	output u2l_pkg::out_word_t result
);

	u2l_pkg::dec_state_t state_q;
	u2l_pkg::dec_state_t state_d;
	logic       valid;
	logic [7:0] ch;
	logic [7:0] b;
	logic [1:0] after;

	assign b     = word.in_byte;
	assign after = word.bytes_after;

	// Decode one byte against the running state
	always_comb begin
		valid   = 1'b0;
		ch      = u2l_pkg::CHAR_NONE;
		state_d = state_q;
		if (state_q.latin_pending) begin
			state_d.latin_pending = 1'b0;
			valid                 = 1'b1;
			ch                    = u2l_pkg::latin_map(b);
		end else if (state_q.skip_left != u2l_pkg::SKIP_NONE) begin
			state_d.skip_left = state_q.skip_left - 2'd1;
		end else if (b < u2l_pkg::ASCII_LIMIT) begin
			valid = 1'b1;
			ch    = b;
		end else if (b == u2l_pkg::LEAD_LATIN && after >= 2'd1) begin
			state_d.latin_pending = 1'b1;
		end else if ((b & u2l_pkg::LEAD2_MASK) == u2l_pkg::LEAD2_MATCH && after >= 2'd1) begin
			state_d.skip_left = u2l_pkg::SKIP_ONE;
		end else if ((b & u2l_pkg::LEAD3_MASK) == u2l_pkg::LEAD3_MATCH && after >= 2'd2) begin
			state_d.skip_left = u2l_pkg::SKIP_TWO;
		end else if ((b & u2l_pkg::LEAD4_MASK) == u2l_pkg::LEAD4_MATCH && after == 2'd3) begin
			state_d.skip_left = u2l_pkg::SKIP_THREE;
		end
		// Clear all state at end of text
		if (after == 2'd0) begin
			state_d.skip_left     = u2l_pkg::SKIP_NONE;
			state_d.latin_pending = 1'b0;
		end
	end

	// Advance state only when the byte moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.skip_left     <= u2l_pkg::SKIP_NONE;
			state_q.latin_pending <= 1'b0;
		end else if (advance) begin
			state_q <= state_d;
		end
	end

	assign result.out_valid = valid;
	assign result.out_char  = ch;
	assign result.text_end  = (after == 2'd0);

endmodule

/* hw/rtl/utf8_to_lcd_transliterator.sv */
// UTF-8 to LCD transliterator. Takes one UTF-8 byte per word, each tagged with the
// count of bytes that follow it (saturated at 3), and returns exactly one character
// word per byte: ASCII passes through, the tail of a 0xC3 pair becomes its ASCII base
// letter, LCD glyph 6/7 (U/O umlaut) or '?' if unmapped, and all other bytes come
// back with out_valid low and out_char zero. The block accepts one byte every cycle
// while its result side is not stalled; a byte's result passes through the input
// register, then the result register. The decoder state (skip count and pending
// flag) is updated once per byte, as the byte moves into the result register.
// Both sides may stall freely; while a result waits the input register can still
// take one more byte.
module utf8_to_lcd_transliterator (
	input logic      clk,
	input logic      arst_n,
	u2l_in_if.sink   byte_stream,
	u2l_out_if.source char_stream
);

	u2l_pkg::in_word_t  in_s1;
	logic               in_vld_s1;
	u2l_pkg::out_word_t out_s2;
	logic               out_vld_s2;
	u2l_pkg::out_word_t dec_result;
	logic               advance;
	logic               out_free;

	// Result register is free when empty or being drained this cycle
	assign out_free = !out_vld_s2 || char_stream.ready;
	assign advance  = in_vld_s1 && out_free;

	// Take a new byte when the input register is empty or moving on
	assign byte_stream.ready = !in_vld_s1 || out_free;

	// Hold the input word
	always_ff @(posedge clk) begin
		if (byte_stream.valid && byte_stream.ready) begin
			in_s1.in_byte     <= byte_stream.in_byte;
			in_s1.bytes_after <= byte_stream.bytes_after;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_s1 <= 1'b0;
		end else if (byte_stream.ready) begin
			in_vld_s1 <= byte_stream.valid;
		end
	end

	u2l_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.word    (in_s1),
		.result  (dec_result)
	);

	// Hold the result word until taken
	always_ff @(posedge clk) begin
		if (advance) begin
			out_s2 <= dec_result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_s2 <= 1'b0;
		end else if (out_free) begin
			out_vld_s2 <= in_vld_s1;
		end
	end

	assign char_stream.valid     = out_vld_s2;
	assign char_stream.out_valid = out_s2.out_valid;
	assign char_stream.out_char  = out_s2.out_char;
	assign char_stream.text_end  = out_s2.text_end;

endmodule

/* hw/rtl/u2l_checker.sv */
`include "utf8_to_lcd_transliterator_macros.svh"

module u2l_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_hs_valid,
	input logic       out_hs_ready,
	input logic       out_valid,
	input logic [7:0] out_char,
	input logic       text_end
);

	logic [9:0] out_word;
	logic       out_stall;

	assign out_word  = {out_valid, out_char, text_end};
	assign out_stall = out_hs_valid && !out_hs_ready;

	// A dropped byte carries no character
	`U2L_ASSERT_NOW(a_drop_zero, out_hs_valid && !out_valid, out_char == 8'h00, "drop has char")

	// Emitted characters are ASCII or a glyph slot, never a high byte
	`U2L_ASSERT_NOW(a_char_range, out_hs_valid && out_valid, !out_char[7], "char not ASCII")

	// No result word is offered right after reset
	`U2L_ASSERT_ALWAYS(a_reset_empty, $rose(arst_n) || !arst_n, !out_hs_valid, "word in reset")

	// A stalled result word holds
	`U2L_ASSERT_NEXT(a_out_hold, out_stall, out_hs_valid && $stable(out_word), "stalled word moved")

endmodule

bind utf8_to_lcd_transliterator u2l_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_hs_valid (char_stream.valid),
	.out_hs_ready (char_stream.ready),
	.out_valid    (char_stream.out_valid),
	.out_char     (char_stream.out_char),
	.text_end     (char_stream.text_end)
);
